// ----- hdl/chirp_matched_filter_defines.svh -----
// Assertion macros for the chirp matched filter RTL, used by cmf_ctrl.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef CHIRP_MATCHED_FILTER_DEFINES_SVH
`define CHIRP_MATCHED_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CMF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cmf_pkg.sv -----
// Shared constants, types and the quarter-wave chirp coefficient table.
// Used by cmf_ctrl, cmf_datapath and chirp_matched_filter; no dependencies.
package cmf_pkg;

  localparam int MAX_TAPS         = 1024;
  localparam int SAMPLE_BITS      = 16;
  localparam int PHASE_TABLE_BITS = 10;
  localparam int COEF_BITS        = 16;

  localparam int ADDR_BITS  = $clog2(MAX_TAPS);
  localparam int CNT_BITS   = ADDR_BITS + 1;
  localparam int PHASE_BITS = 32;
  localparam int OUT_BITS   = 32;
  localparam int CFG_BITS   = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int TAPCNT_BITS  = 11;
  localparam int SHIFT_BITS   = 5;

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + ADDR_BITS;
  localparam int MAG_BITS  = ACC_BITS - 1;
  localparam int SQ_BITS   = 2 * MAG_BITS + 1;
  localparam int ROOT_BITS = (SQ_BITS + 1) / 2;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 4;
  localparam int STEP_CNT_BITS = $clog2(ROOT_BITS + 1);
  localparam int DRAIN_CYCLES  = 3;

  localparam int QUARTER     = 1 << (PHASE_TABLE_BITS - 2);
  localparam int ROW_BITS    = PHASE_TABLE_BITS - 2;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned AMP         = (64'd1 << (COEF_BITS - 1)) - 64'd1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_STEP  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_GROWTH = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_SHIFT   = 2'd3;

  localparam int unsigned SIN_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};
  localparam int unsigned COS_DIV [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};

  typedef logic [COEF_BITS-1:0] quarter_tab_t [QUARTER];

  typedef struct packed {
    logic signed [COEF_BITS-1:0] cosv;
    logic signed [COEF_BITS-1:0] sinv;
  } coef_pair_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic issue;
    logic sq_load_re;
    logic sq_load_im;
    logic sq_step;
    logic rt_load;
    logic rt_step;
    logic out_load;
  } cmf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_tap;
    logic out_free;
  } cmf_sts_t;

  function automatic logic [COEF_BITS-1:0] scale_coef(logic signed [63:0] v);
    logic signed [63:0] c;
    logic [63:0] t;
    c = v;
    if (c < 0) c = 64'sd0;
    if (c > $signed(ONE_Q30)) c = $signed(ONE_Q30);
    t = ($unsigned(c) * AMP + (64'd1 << 29)) >> 30;
    return t[COEF_BITS-1:0];
  endfunction

  // Taylor series in Q30 for every quarter-wave row, evaluated at elaboration.
  function automatic quarter_tab_t build_tab(bit want_sin);
    quarter_tab_t tab;
    logic [63:0] x, x2, ts, tc;
    logic signed [63:0] s, c;
    for (int r = 0; r < QUARTER; r++) begin
      x  = (64'(r) * HALF_PI_Q30 + 64'(QUARTER / 2)) >> ROW_BITS;
      x2 = (x * x) >> 30;
      ts = x;
      tc = ONE_Q30;
      s  = $signed(x);
      c  = $signed(ONE_Q30);
      for (int n = 1; n <= 10; n++) begin
        ts = ((ts * x2) >> 30) / 64'(SIN_DIV[n-1]);
        tc = ((tc * x2) >> 30) / 64'(COS_DIV[n-1]);
        if ((n % 2) == 1) begin
          s = s - $signed(ts);
          c = c - $signed(tc);
        end else begin
          s = s + $signed(ts);
          c = c + $signed(tc);
        end
      end
      tab[r] = want_sin ? scale_coef(s) : scale_coef(c);
    end
    return tab;
  endfunction

  localparam quarter_tab_t SIN_TAB = build_tab(1'b1);
  localparam quarter_tab_t COS_TAB = build_tab(1'b0);

  // Full-wave cosine and sine from the top phase bits by quadrant symmetry.
  function automatic coef_pair_t coef_lookup(logic [PHASE_TABLE_BITS-1:0] k);
    coef_pair_t p;
    logic signed [COEF_BITS-1:0] qs, qc;
    qs = $signed(SIN_TAB[k[ROW_BITS-1:0]]);
    qc = $signed(COS_TAB[k[ROW_BITS-1:0]]);
    case (k[PHASE_TABLE_BITS-1 -: 2])
      2'd0: begin
        p.cosv = qc;
        p.sinv = qs;
      end
      2'd1: begin
        p.cosv = -qs;
        p.sinv = qc;
      end
      2'd2: begin
        p.cosv = -qc;
        p.sinv = -qs;
      end
      default: begin
        p.cosv = qs;
        p.sinv = -qc;
      end
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/cmf_ctrl.sv -----
// Sequencing state machine of the chirp matched filter.
// Depends on cmf_pkg and chirp_matched_filter_defines.svh.
`include "chirp_matched_filter_defines.svh"

module cmf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output cmf_pkg::cmf_cmd_t cmd,
  input  cmf_pkg::cmf_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAPS,
    ST_DRAIN,
    ST_SQ_LOAD_RE,
    ST_SQ_RE,
    ST_SQ_LOAD_IM,
    ST_SQ_IM,
    ST_RT_LOAD,
    ST_RT,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic [cmf_pkg::STEP_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic in_stall_r;

  assign in_stall = in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = ST_TAPS;
      end
      ST_TAPS: begin
        cmd.issue = 1'b1;
        cnt_nxt   = '0;
        if (sts.last_tap) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cnt_r == cmf_pkg::STEP_CNT_BITS'(cmf_pkg::DRAIN_CYCLES - 1)) begin
          state_nxt = ST_SQ_LOAD_RE;
        end
      end
      ST_SQ_LOAD_RE: begin
        cmd.sq_load_re = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = ST_SQ_RE;
      end
      ST_SQ_RE: begin
        cmd.sq_step = 1'b1;
        if (cnt_r == cmf_pkg::STEP_CNT_BITS'(cmf_pkg::MAG_BITS - 1)) state_nxt = ST_SQ_LOAD_IM;
      end
      ST_SQ_LOAD_IM: begin
        cmd.sq_load_im = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        cmd.sq_step = 1'b1;
        if (cnt_r == cmf_pkg::STEP_CNT_BITS'(cmf_pkg::MAG_BITS - 1)) state_nxt = ST_RT_LOAD;
      end
      ST_RT_LOAD: begin
        cmd.rt_load = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_RT;
      end
      ST_RT: begin
        cmd.rt_step = 1'b1;
        if (cnt_r == cmf_pkg::STEP_CNT_BITS'(cmf_pkg::ROOT_BITS - 1)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

  `CMF_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall_r, state_r == ST_TAPS, "accepted request did not start the tap loop")
  `CMF_ASSERT_NEXT(a_last_tap_drains, state_r == ST_TAPS && sts.last_tap, state_r == ST_DRAIN, "tap loop did not end after the last tap")
  `CMF_ASSERT_IMP(a_out_load_free, cmd.out_load, sts.out_free, "result loaded over a waiting result")
  `CMF_ASSERT_IMP(a_stall_when_busy, state_r != ST_IDLE, in_stall_r, "input not stalled while busy")

endmodule

// ----- hdl/cmf_datapath.sv -----
// Datapath: configuration registers, sample history memory, tap MAC pipeline,
// serial squarer, serial square root and output register. Depends on cmf_pkg.
module cmf_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [cmf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [cmf_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic signed [cmf_pkg::SAMPLE_BITS-1:0] in_sample,
  input  cmf_pkg::cmf_cmd_t                    cmd,
  output cmf_pkg::cmf_sts_t                    sts,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [cmf_pkg::OUT_BITS-1:0]         out_magnitude
);

  localparam int AB = cmf_pkg::ADDR_BITS;

  // Configuration.
  logic [cmf_pkg::TAPCNT_BITS-1:0] tap_count_r;
  logic [cmf_pkg::PHASE_BITS-1:0]  first_step_r, growth_r;
  logic [cmf_pkg::SHIFT_BITS-1:0]  out_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r  <= cmf_pkg::TAPCNT_BITS'(cmf_pkg::MAX_TAPS);
      first_step_r <= '0;
      growth_r     <= '0;
      out_shift_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cmf_pkg::REG_TAP_COUNT:   tap_count_r  <= cfg_data[cmf_pkg::TAPCNT_BITS-1:0];
        cmf_pkg::REG_FIRST_STEP:  first_step_r <= cfg_data[cmf_pkg::PHASE_BITS-1:0];
        cmf_pkg::REG_STEP_GROWTH: growth_r     <= cfg_data[cmf_pkg::PHASE_BITS-1:0];
        cmf_pkg::REG_OUT_SHIFT:   out_shift_r  <= cfg_data[cmf_pkg::SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Window length, clamped to 1..MAX_TAPS, less one.
  logic [AB-1:0] len_m1;
  always_comb begin
    if (tap_count_r == '0) begin
      len_m1 = '0;
    end else if (tap_count_r > cmf_pkg::TAPCNT_BITS'(cmf_pkg::MAX_TAPS)) begin
      len_m1 = AB'(cmf_pkg::MAX_TAPS - 1);
    end else begin
      len_m1 = AB'(tap_count_r - 1'b1);
    end
  end

  // History memory with a fill count in place of a clearing pass.
  logic [cmf_pkg::SAMPLE_BITS-1:0] hist_mem_r [cmf_pkg::MAX_TAPS];
  logic [AB-1:0] newest_r, newest_nxt;
  logic [cmf_pkg::CNT_BITS-1:0] fill_r;
  logic [AB-1:0] pos_r, tap_left_r;
  logic [cmf_pkg::PHASE_BITS-1:0] phase_r, step_r;
  logic [cmf_pkg::SAMPLE_BITS-1:0] rdata_r;

  assign newest_nxt = newest_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.accept) hist_mem_r[newest_nxt] <= in_sample;
    rdata_r <= hist_mem_r[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      fill_r   <= '0;
    end else if (cmd.accept) begin
      newest_r <= newest_nxt;
      if (fill_r != cmf_pkg::CNT_BITS'(cmf_pkg::MAX_TAPS)) fill_r <= fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_r      <= newest_nxt - len_m1;
      tap_left_r <= len_m1;
      phase_r    <= '0;
      step_r     <= first_step_r;
    end else if (cmd.issue) begin
      pos_r      <= pos_r + 1'b1;
      tap_left_r <= tap_left_r - 1'b1;
      phase_r    <= phase_r + step_r;
      step_r     <= step_r + growth_r;
    end
  end

  assign sts.last_tap = (tap_left_r == '0);

  logic pos_written;
  assign pos_written = (fill_r == cmf_pkg::CNT_BITS'(cmf_pkg::MAX_TAPS)) ||
                       ((pos_r != '0) && ({1'b0, pos_r} <= fill_r));

  // MAC pipeline: read, table lookup, multiply, accumulate.
  logic v1_r, v2_r, v3_r, ok1_r;
  logic [cmf_pkg::PHASE_TABLE_BITS-1:0] k1_r;
  logic signed [cmf_pkg::SAMPLE_BITS-1:0] s2_r;
  cmf_pkg::coef_pair_t coef2_r;
  logic signed [cmf_pkg::PROD_BITS-1:0] p_re_r, p_im_r;
  logic signed [cmf_pkg::ACC_BITS-1:0] acc_re_r, acc_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ok1_r   <= pos_written;
    k1_r    <= phase_r[cmf_pkg::PHASE_BITS-1 -: cmf_pkg::PHASE_TABLE_BITS];
    s2_r    <= ok1_r ? $signed(rdata_r) : '0;
    coef2_r <= cmf_pkg::coef_lookup(k1_r);
    p_re_r  <= s2_r * coef2_r.cosv;
    p_im_r  <= s2_r * coef2_r.sinv;
    if (cmd.accept) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v3_r) begin
      acc_re_r <= acc_re_r + cmf_pkg::ACC_BITS'(p_re_r);
      acc_im_r <= acc_im_r + cmf_pkg::ACC_BITS'(p_im_r);
    end
  end

  // Shift-and-add squarer, one multiplier bit a cycle, re then im.
  logic [cmf_pkg::ACC_BITS-1:0] abs_re, abs_im;
  logic [cmf_pkg::SQ_BITS-1:0] sq_acc_r, sq_add_r;
  logic [cmf_pkg::MAG_BITS-1:0] sq_mul_r;

  assign abs_re = acc_re_r[cmf_pkg::ACC_BITS-1] ? -acc_re_r : acc_re_r;
  assign abs_im = acc_im_r[cmf_pkg::ACC_BITS-1] ? -acc_im_r : acc_im_r;

  always_ff @(posedge clk) begin
    if (cmd.sq_load_re) begin
      sq_acc_r <= '0;
      sq_add_r <= cmf_pkg::SQ_BITS'(abs_re[cmf_pkg::MAG_BITS-1:0]);
      sq_mul_r <= abs_re[cmf_pkg::MAG_BITS-1:0];
    end else if (cmd.sq_load_im) begin
      sq_add_r <= cmf_pkg::SQ_BITS'(abs_im[cmf_pkg::MAG_BITS-1:0]);
      sq_mul_r <= abs_im[cmf_pkg::MAG_BITS-1:0];
    end else if (cmd.sq_step) begin
      if (sq_mul_r[0]) sq_acc_r <= sq_acc_r + sq_add_r;
      sq_add_r <= sq_add_r << 1;
      sq_mul_r <= sq_mul_r >> 1;
    end
  end

  // Restoring square root, one result bit a cycle.
  logic [cmf_pkg::RAD_BITS-1:0] rad_r;
  logic [cmf_pkg::REM_BITS-1:0] rem_r, rem_sh, trial;
  logic [cmf_pkg::ROOT_BITS-1:0] root_r;

  assign rem_sh = {rem_r[cmf_pkg::REM_BITS-3:0], rad_r[cmf_pkg::RAD_BITS-1 -: 2]};
  assign trial  = cmf_pkg::REM_BITS'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.rt_load) begin
      rad_r  <= cmf_pkg::RAD_BITS'(sq_acc_r);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.rt_step) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[cmf_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[cmf_pkg::ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  // Output register with shift and saturation.
  logic [cmf_pkg::ROOT_BITS-1:0] root_sh;
  logic [cmf_pkg::OUT_BITS-1:0] mag_nxt;
  logic out_valid_r;
  logic [cmf_pkg::OUT_BITS-1:0] out_mag_r;

  assign root_sh = root_r >> out_shift_r;
  assign mag_nxt = (|root_sh[cmf_pkg::ROOT_BITS-1:cmf_pkg::OUT_BITS]) ? '1 :
                   root_sh[cmf_pkg::OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_mag_r <= mag_nxt;
  end

  assign sts.out_free   = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_magnitude  = out_mag_r;

endmodule

// ----- hdl/chirp_matched_filter.sv -----
// Top level of the linear FM chirp matched filter.
// Depends on cmf_pkg, cmf_ctrl and cmf_datapath.

// Each accepted sample is written into a 1024-entry history memory and the
// newest tap_count samples are correlated with a complex linear FM chirp whose
// phase comes from a quadratic phase accumulator driving a quarter-wave
// sine/cosine table. One tap is processed per clock through a single memory read
// port and a pair of 16x16 multipliers. A request runs through the tap loop, the
// pipeline drain, bit-serial squaring of the real and imaginary sums, a bit-serial
// square root and the loading and hand-over of the result. Only one request is in
// flight at a time; the result sits in an output register, so the next request is
// taken while the previous result still waits. History entries not yet written
// since reset read as zero through a fill count, so there is no clearing pass
// after reset. Configuration writes are expected only while the block is idle.
module chirp_matched_filter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [cmf_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [cmf_pkg::CFG_BITS-1:0]           cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [cmf_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [cmf_pkg::OUT_BITS-1:0]           out_magnitude
);

  // Commands flow from the controller to the datapath and status flows back.
  cmf_pkg::cmf_cmd_t cmd;
  cmf_pkg::cmf_sts_t sts;

  cmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  cmf_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_sample     (in_sample),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_magnitude (out_magnitude)
  );

endmodule

// ----- test/chirp_matched_filter_test.sv -----
// Self-checking testbench for the chirp matched filter: directed and random requests.
// Depends on cmf_pkg and chirp_matched_filter; it carries its own correlator model.
module chirp_matched_filter_test;

  localparam int QTR = 256;
  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 10000000;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [cmf_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [cmf_pkg::CFG_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [cmf_pkg::SAMPLE_BITS-1:0] in_sample;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [cmf_pkg::OUT_BITS-1:0] out_magnitude;

  chirp_matched_filter dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_magnitude(out_magnitude)
  );

  // Model state: the window of recent samples and the register copies.
  int quarter_sine [QTR];
  int quarter_cosine [QTR];
  logic signed [15:0] sample_line [DEPTH];
  int unsigned write_slot;
  logic [10:0] window_taps;
  logic [31:0] phase_step0;
  logic [31:0] phase_growth;
  logic [4:0] mag_shift;

  logic [31:0] magnitudes_due [$];
  int errors;
  int cycle_count;
  int accepted;

  // A directed request: the sample, and a literal result where one is obvious.
  typedef struct {
    logic signed [15:0] sample;
    bit literal;
    logic [31:0] magnitude;
  } sample_row_t;

  sample_row_t directed_rows [16] = '{
    '{16'sh7FFF, 1'b1, 32'd1073676289},
    '{16'sh8000, 1'b1, 32'd32767},
    '{16'sh8000, 1'b1, 32'd1073741823},
    '{16'sh0000, 1'b1, 32'd1073741823},
    '{16'sh0001, 1'b0, 32'd0},
    '{16'shFFFF, 1'b0, 32'd0},
    '{16'sh5555, 1'b0, 32'd0},
    '{16'shAAAA, 1'b0, 32'd0},
    '{16'sh7FFF, 1'b0, 32'd0},
    '{16'sh7FFF, 1'b0, 32'd0},
    '{16'sh8000, 1'b0, 32'd0},
    '{16'sh00FF, 1'b0, 32'd0},
    '{16'shFF00, 1'b0, 32'd0},
    '{16'sh0F0F, 1'b0, 32'd0},
    '{16'shF0F0, 1'b0, 32'd0},
    '{16'sh1234, 1'b0, 32'd0}
  };

  // The quarter-wave table, from a Taylor series held in Q30.
  function automatic int to_coef(longint v);
    longint c;
    c = v;
    if (c < 0) c = 0;
    if (c > 64'd1073741824) c = 64'd1073741824;
    return int'((longint'(c) * 32767 + (64'd1 << 29)) >>> 30);
  endfunction

  task automatic fill_quarter_wave();
    longint unsigned x, x2, ts, tc;
    longint s, c;
    for (int r = 0; r < QTR; r++) begin
      x = (longint'(r) * 64'd1686629713 + 64'd128) >> 8;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1073741824;
      s = longint'(x);
      c = 64'd1073741824;
      for (int n = 1; n <= 10; n++) begin
        ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          s -= longint'(ts);
          c -= longint'(tc);
        end else begin
          s += longint'(ts);
          c += longint'(tc);
        end
      end
      quarter_sine[r] = to_coef(s);
      quarter_cosine[r] = to_coef(c);
    end
  endtask

  // Stores the sample and returns the shifted, saturated correlation magnitude.
  function automatic logic [31:0] correlate_sample(logic signed [15:0] x);
    int unsigned taps, pos;
    logic [31:0] phase, step;
    logic [9:0] k;
    int cv, sv, qs, qc;
    longint re, im;
    logic [47:0] are, aim, root, trial;
    logic [95:0] power;
    logic [47:0] shifted;
    write_slot = (write_slot + 1) % DEPTH;
    sample_line[write_slot] = x;
    taps = window_taps;
    if (taps < 1) taps = 1;
    if (taps > DEPTH) taps = DEPTH;
    pos = (write_slot + DEPTH - (taps - 1)) % DEPTH;
    phase = 0;
    step = phase_step0;
    re = 0;
    im = 0;
    for (int j = 0; j < taps; j++) begin
      k = phase[31:22];
      qs = quarter_sine[k[7:0]];
      qc = quarter_cosine[k[7:0]];
      case (k[9:8])
        2'd0: begin cv = qc; sv = qs; end
        2'd1: begin cv = -qs; sv = qc; end
        2'd2: begin cv = -qc; sv = -qs; end
        default: begin cv = qs; sv = -qc; end
      endcase
      re += longint'(sample_line[pos]) * cv;
      im += longint'(sample_line[pos]) * sv;
      phase += step;
      step += phase_growth;
      pos = (pos + 1) % DEPTH;
    end
    are = (re < 0) ? 48'(-re) : 48'(re);
    aim = (im < 0) ? 48'(-im) : 48'(im);
    power = 96'(are) * 96'(are) + 96'(aim) * 96'(aim);
    root = 0;
    for (int b = 47; b >= 0; b--) begin
      trial = root | (48'd1 << b);
      if (96'(trial) * 96'(trial) <= power) root = trial;
    end
    shifted = root >> mag_shift;
    return (shifted > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : shifted[31:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Runaway guard: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: compare each accepted result, then choose the next stall.
  int stall_left;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (magnitudes_due.size() == 0) begin
        $display("%0t: unexpected result, actual %0d", $time, out_magnitude);
        errors++;
      end else begin
        if (out_magnitude !== magnitudes_due[0]) begin
          $display("%0t: magnitude mismatch, expected %0d actual %0d",
                   $time, magnitudes_due[0], out_magnitude);
          errors++;
        end
        void'(magnitudes_due.pop_front());
      end
    end
    // Mostly free running, with short stalls and the odd long one.
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(19))
        0, 1, 2: stall_left = $urandom_range(3);
        3: stall_left = $urandom_range(1600, 40);
        default: stall_left = 0;
      endcase
      out_stall <= (stall_left > 0);
    end
  end

  // Configuration is written only once the block has nothing outstanding.
  task automatic write_register(logic [cmf_pkg::CFG_IDX_BITS-1:0] index, logic [31:0] value);
    wait (magnitudes_due.size() == 0);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (index)
      cmf_pkg::REG_TAP_COUNT: window_taps = value[10:0];
      cmf_pkg::REG_FIRST_STEP: phase_step0 = value;
      cmf_pkg::REG_STEP_GROWTH: phase_growth = value;
      cmf_pkg::REG_OUT_SHIFT: mag_shift = value[4:0];
      default: ;
    endcase
  endtask

  task automatic set_chirp(logic [10:0] taps, logic [31:0] step0, logic [31:0] growth,
                           logic [4:0] shift);
    // Bits above each register's width carry noise that the block must ignore.
    write_register(cmf_pkg::REG_TAP_COUNT, {21'($urandom_range(2097151)), taps});
    write_register(cmf_pkg::REG_FIRST_STEP, step0);
    write_register(cmf_pkg::REG_STEP_GROWTH, growth);
    write_register(cmf_pkg::REG_OUT_SHIFT, {27'($urandom_range(134217727)), shift});
  endtask

  // One request: an optional gap, then hold the sample until it is taken.
  task automatic send_sample(logic signed [15:0] x, bit literal, logic [31:0] literal_mag);
    int gap;
    logic [31:0] predicted;
    case ($urandom_range(15))
      0, 1, 2, 3: gap = $urandom_range(3, 1);
      4: gap = $urandom_range(60, 10);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_sample <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (in_stall);
    predicted = correlate_sample(x);
    magnitudes_due.push_back(literal ? literal_mag : predicted);
    accepted++;
  endtask

  function automatic logic signed [15:0] random_sample(bit loud);
    if (loud) return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
    case ($urandom_range(7))
      0: return 16'($urandom_range(255));
      1: return 16'sh8000 + 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [10:0] taps;
    int count;
    bit loud;
    errors = 0;
    cycle_count = 0;
    accepted = 0;
    stall_left = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_sample = '0;
    fill_quarter_wave();
    for (int i = 0; i < DEPTH; i++) sample_line[i] = '0;
    write_slot = 0;
    window_taps = 11'd1024;
    phase_step0 = 0;
    phase_growth = 0;
    mag_shift = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: a flat chirp over the full window, so the
    // first results are just the running sum times full-scale cosine.
    foreach (directed_rows[i])
      send_sample(directed_rows[i].sample, directed_rows[i].literal,
                  directed_rows[i].magnitude);
    in_valid <= 1'b0;

    // Tap count zero acts as a single tap; above the maximum it saturates.
    set_chirp(11'd0, 32'h1234_5678, 32'h0000_1000, 5'd0);
    for (int i = 0; i < 8; i++) send_sample(random_sample(0), 0, 0);
    in_valid <= 1'b0;
    set_chirp(11'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    for (int i = 0; i < 4; i++) send_sample(random_sample(0), 0, 0);
    in_valid <= 1'b0;

    // Random settings, mostly short windows, each with a run of requests.
    while (accepted < 550) begin
      case ($urandom_range(9))
        0: taps = 11'd1024;
        1: taps = 11'($urandom_range(2047, 1025));
        2: taps = 11'd1;
        default: taps = 11'($urandom_range(64, 2));
      endcase
      set_chirp(taps, $urandom, ($urandom_range(1) != 0) ? $urandom : $urandom_range(65535),
                ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd0);
      count = (taps >= 11'd1024) ? 6 : 50;
      // Some runs hammer the window with full-scale values to drive saturation.
      loud = ($urandom_range(4) == 0);
      for (int i = 0; i < count; i++) begin
        send_sample(random_sample(loud), 0, 0);
        if (i == count / 2 && $urandom_range(3) == 0) begin
          // Hold back until the block has drained completely.
          in_valid <= 1'b0;
          wait (magnitudes_due.size() == 0);
          @(posedge clk);
        end
      end
      in_valid <= 1'b0;
    end

    in_valid <= 1'b0;
    wait (magnitudes_due.size() == 0);
    repeat (1300) @(posedge clk);
    if (errors == 0 && magnitudes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/cmf_pkg.sv
hdl/cmf_ctrl.sv
hdl/cmf_datapath.sv
hdl/chirp_matched_filter.sv
test/chirp_matched_filter_test.sv
